[design/vnmr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vnmr_pkg
// Shared types, codes and constants of the virtio-mmio network register file.
// ----------------------------------------------------------------------------
package vnmr_pkg;

  // Sizing
  localparam int unsigned QueueCountDefault = 2;
  localparam int unsigned QueueSizeMax      = 64;
  localparam int unsigned TxQueueIndex      = 1;
  localparam int unsigned RxQueueIndex      = TxQueueIndex ^ 1;

  // Access function codes
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_EVENT = 2'd2;

  // Register offsets
  localparam logic [8:0] OFS_MAGIC         = 9'h000;
  localparam logic [8:0] OFS_VERSION       = 9'h004;
  localparam logic [8:0] OFS_DEVICE_ID     = 9'h008;
  localparam logic [8:0] OFS_VENDOR        = 9'h00C;
  localparam logic [8:0] OFS_DEV_FEATURES  = 9'h010;
  localparam logic [8:0] OFS_DEV_FEAT_SEL  = 9'h014;
  localparam logic [8:0] OFS_QUEUE_SEL     = 9'h030;
  localparam logic [8:0] OFS_QUEUE_NUM_MAX = 9'h034;
  localparam logic [8:0] OFS_QUEUE_NUM     = 9'h038;
  localparam logic [8:0] OFS_QUEUE_READY   = 9'h044;
  localparam logic [8:0] OFS_QUEUE_NOTIFY  = 9'h050;
  localparam logic [8:0] OFS_IRQ_STATUS    = 9'h060;
  localparam logic [8:0] OFS_IRQ_ACK       = 9'h064;
  localparam logic [8:0] OFS_STATUS        = 9'h070;
  localparam logic [8:0] OFS_CONFIG_GEN    = 9'h0FC;
  localparam logic [8:0] OFS_MAC_LO        = 9'h100;
  localparam logic [8:0] OFS_MAC_HI        = 9'h104;

  // Identity words
  localparam logic [31:0] MAGIC_WORD   = 32'h7472_6976;
  localparam logic [31:0] VERSION_VAL  = 32'd2;
  localparam logic [31:0] DEVICE_ID    = 32'd1;
  localparam logic [31:0] VENDOR_WORD  = 32'h494D_5246;
  localparam logic [31:0] FEATURE_BITS = 32'h1;

  // Status and interrupt bits
  localparam int unsigned  StatusDriverOkBit = 2;
  localparam logic [31:0]  IRQ_USED_RING     = 32'h1;

  // MAC reset value, byte 0 in bits 7:0
  localparam logic [47:0] MAC_RESET = 48'h01_49_4D_52_46_52;

  // One access beat
  typedef struct packed {
    logic [1:0]  func;
    logic [8:0]  offset;
    logic [31:0] wdata;
  } req_t;

  // One result beat
  typedef struct packed {
    logic [31:0] rdata;
    logic        tx_kick;
    logic        irq_pulse;
  } rsp_t;

endpackage
`default_nettype wire

[design/virtio_net_mmio_register_file.sv]
`default_nettype none
// Pipeline: an accepted access beat passes through the input register, then
//   the result register, before its result shows.
// Throughput: one access per cycle; both stages advance together unless
//   the result register is held by out_stall_i.
// Reset: rst_ni clears all live registers and both stage valids; the MAC
//   register returns to 01:49:4D:52:46:52 in byte order 5..0.
// ----------------------------------------------------------------------------
// virtio_net_mmio_register_file
// virtio-mmio v2 register file of a network device: reads, writes and
// receive delivery events, each access as one beat through a two-stage pipe.
// ----------------------------------------------------------------------------
module virtio_net_mmio_register_file import vnmr_pkg::*; #(
  parameter int unsigned QueueCount = QueueCountDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // access channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire req_t        in_data_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output rsp_t             out_data_o,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [47:0] cfg_wdata_i
);

  logic  in_valid_q;
  req_t  in_data_q;
  logic  out_valid_q;
  rsp_t  out_data_q;
  rsp_t  rsp;
  logic  advance;
  logic  in_fire;

  // staged beat moves on when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  vnmr_core #(
    .QueueCount(QueueCount)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .advance_i  (advance),
    .req_i      (in_data_q),
    .rsp_o      (rsp)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_data_q <= in_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

[design/vnmr_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vnmr_core
// Register state, access decode and result generation. Live state (not the MAC)
// is updated on the edge at which the staged access moves into the result register.
// ----------------------------------------------------------------------------
module vnmr_core import vnmr_pkg::*; #(
  parameter int unsigned QueueCount = QueueCountDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [47:0] cfg_wdata_i,
  input  wire logic        advance_i,
  input  wire req_t        req_i,
  output rsp_t             rsp_o
);

  localparam int unsigned QW = (QueueCount > 1) ? $clog2(QueueCount) : 1;

  logic [47:0] mac_q;
  logic [31:0] status_q, status_d;
  logic [31:0] feat_sel_q, feat_sel_d;
  logic [31:0] irq_q, irq_d;
  logic [31:0] qsel_q, qsel_d;
  logic [31:0] qsize_q [QueueCount];
  logic [31:0] qsize_d [QueueCount];
  logic        qready_q [QueueCount];
  logic        qready_d [QueueCount];

  logic          qsel_ok;
  logic [QW-1:0] cur_q;
  logic [31:0]   rdata;
  logic          kick;

  // current queue, falls back to queue 0 when the select is out of range
  assign qsel_ok = (qsel_q < 32'(QueueCount));
  assign cur_q   = qsel_ok ? qsel_q[QW-1:0] : '0;

  // read mux
  always_comb begin
    unique case (req_i.offset)
      OFS_MAGIC:         rdata = MAGIC_WORD;
      OFS_VERSION:       rdata = VERSION_VAL;
      OFS_DEVICE_ID:     rdata = DEVICE_ID;
      OFS_VENDOR:        rdata = VENDOR_WORD;
      OFS_DEV_FEATURES:  rdata = (feat_sel_q == 32'd1) ? FEATURE_BITS : '0;
      OFS_QUEUE_NUM_MAX: rdata = qsel_ok ? 32'(QueueSizeMax) : '0;
      OFS_QUEUE_READY:   rdata = {31'd0, qready_q[cur_q]};
      OFS_IRQ_STATUS:    rdata = irq_q;
      OFS_STATUS:        rdata = status_q;
      OFS_CONFIG_GEN:    rdata = '0;
      OFS_MAC_LO:        rdata = mac_q[31:0];
      OFS_MAC_HI:        rdata = {16'd0, mac_q[47:32]};
      default:           rdata = '0;
    endcase
  end

  // transmit notify check
  assign kick = (req_i.wdata == 32'(TxQueueIndex)) &&
                status_q[StatusDriverOkBit] &&
                qready_q[TxQueueIndex] && qready_q[RxQueueIndex] &&
                (qsize_q[TxQueueIndex] != '0) && (qsize_q[RxQueueIndex] != '0);

  // next state and result
  always_comb begin
    status_d   = status_q;
    feat_sel_d = feat_sel_q;
    irq_d      = irq_q;
    qsel_d     = qsel_q;
    qsize_d    = qsize_q;
    qready_d   = qready_q;
    rsp_o      = '0;
    unique case (req_i.func)
      FUNC_READ: begin
        rsp_o.rdata = rdata;
      end
      FUNC_WRITE: begin
        unique case (req_i.offset)
          OFS_DEV_FEAT_SEL: feat_sel_d = req_i.wdata;
          OFS_QUEUE_SEL:    qsel_d = req_i.wdata;
          OFS_QUEUE_NUM:    qsize_d[cur_q] = req_i.wdata;
          OFS_QUEUE_READY:  qready_d[cur_q] = req_i.wdata[0];
          OFS_QUEUE_NOTIFY: rsp_o.tx_kick = kick;
          OFS_IRQ_ACK:      irq_d = irq_q & ~req_i.wdata;
          OFS_STATUS: begin
            status_d = req_i.wdata;
            // device reset: drop interrupts and every queue's size and ready bit
            if (req_i.wdata == '0) begin
              irq_d = '0;
              for (int i = 0; i < QueueCount; i++) begin
                qsize_d[i]  = '0;
                qready_d[i] = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      FUNC_EVENT: begin
        irq_d           = irq_q | IRQ_USED_RING;
        rsp_o.irq_pulse = 1'b1;
      end
      default: ;
    endcase
  end

  // MAC register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q <= MAC_RESET;
    end else if (cfg_we_i) begin
      mac_q <= cfg_wdata_i;
    end
  end

  // live registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q   <= '0;
      feat_sel_q <= '0;
      irq_q      <= '0;
      qsel_q     <= '0;
      for (int i = 0; i < QueueCount; i++) begin
        qsize_q[i]  <= '0;
        qready_q[i] <= 1'b0;
      end
    end else if (advance_i) begin
      status_q   <= status_d;
      feat_sel_q <= feat_sel_d;
      irq_q      <= irq_d;
      qsel_q     <= qsel_d;
      qsize_q    <= qsize_d;
      qready_q   <= qready_d;
    end
  end

endmodule
`default_nettype wire
